// ----- rtl/core/dm_pkg.sv -----
// ----------------------------------------------------------------------------
// dm_pkg
// Shared constants, codes and control structs for the block density matrix.
// ----------------------------------------------------------------------------
package dm_pkg;

  localparam int MAX_N     = 32;
  localparam int FRAC_BITS = 14;

  localparam int IDX_W  = 5;
  localparam int VAL_W  = 16;
  localparam int OP_W   = 2;
  localparam int SIZE_W = 6;
  localparam int GIDX_W = 12;
  localparam int PIDX_W = 24;
  localparam int OUT_W  = 34;
  localparam int OUT_FRAC = 30;

  localparam int MA_W  = $clog2(MAX_N);
  localparam int EA_W  = $clog2(MAX_N * MAX_N);
  localparam int CNT_W = $clog2(MAX_N + 1);
  localparam int CMP_W = 8;

  // w*a*b is 3*VAL_W bits, doubled adds one, sum over MAX_N terms adds the rest
  localparam int ACC_W = 3 * VAL_W + 1 + $clog2(MAX_N);

  localparam logic [OP_W-1:0] OP_LOAD_OCC = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_VEC = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE  = 2'd2;

  localparam logic REG_BLOCK_SIZE   = 1'b0;
  localparam logic REG_BLOCK_OFFSET = 1'b1;

  localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST = 6'd32;

  typedef struct packed {
    logic              occ_we;
    logic              eig_we;
    logic [MA_W-1:0]   occ_addr;
    logic [EA_W-1:0]   eig_addr;
    logic [VAL_W-1:0]  data;
  } dm_wr_t;

  typedef struct packed {
    logic [MA_W-1:0]   occ_addr;
    logic [EA_W-1:0]   a_addr;
    logic [EA_W-1:0]   b_addr;
  } dm_rd_t;

  typedef struct packed {
    logic clr;
    logic issue;
  } dm_mac_ctl_t;

endpackage

// ----- rtl/core/dm_in_if.sv -----
// ----------------------------------------------------------------------------
// dm_in_if
// Request channel: load occupation, load eigenvector element, or compute.
// ----------------------------------------------------------------------------
interface dm_in_if;
  import dm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [IDX_W-1:0]        index_k;
  logic [IDX_W-1:0]        index_i;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, op, index_k, index_i, value, input ready);
  modport sink   (input valid, op, index_k, index_i, value, output ready);
endinterface

// ----- rtl/core/dm_out_if.sv -----
// ----------------------------------------------------------------------------
// dm_out_if
// Result channel: one density matrix element with its addresses and status.
// ----------------------------------------------------------------------------
interface dm_out_if;
  import dm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [GIDX_W-1:0]       row_global;
  logic [GIDX_W-1:0]       col_global;
  logic [PIDX_W-1:0]       packed_index;
  logic signed [OUT_W-1:0] density_value;
  logic                    status;

  modport source (output valid, row_global, col_global, packed_index, density_value,
                  status, input ready);
  modport sink   (input valid, row_global, col_global, packed_index, density_value,
                  status, output ready);
endinterface

// ----- rtl/core/dm_store.sv -----
// ----------------------------------------------------------------------------
// dm_store
// Occupation and eigenvector memories; one write port, registered reads.
// ----------------------------------------------------------------------------
module dm_store (
  input  logic                    clk,
  input  dm_pkg::dm_wr_t          wr,
  input  dm_pkg::dm_rd_t          rd,
  output logic [dm_pkg::VAL_W-1:0] occ_q,
  output logic [dm_pkg::VAL_W-1:0] a_q,
  output logic [dm_pkg::VAL_W-1:0] b_q
);
  import dm_pkg::*;

  logic [VAL_W-1:0] occ_mem [MAX_N];
  logic [VAL_W-1:0] eig_mem [MAX_N * MAX_N];

  always_ff @(posedge clk) begin
    if (wr.occ_we) begin
      occ_mem[wr.occ_addr] <= wr.data;
    end
    occ_q <= occ_mem[rd.occ_addr];
  end

  // eigenvector matrix: row k at k*MAX_N, two read ports for columns i and j
  always_ff @(posedge clk) begin
    if (wr.eig_we) begin
      eig_mem[wr.eig_addr] <= wr.data;
    end
    a_q <= eig_mem[rd.a_addr];
    b_q <= eig_mem[rd.b_addr];
  end

endmodule

// ----- rtl/core/dm_mac.sv -----
// ----------------------------------------------------------------------------
// dm_mac
// Shared multiply-accumulate: w*a, then *b, then doubled into the sum;
// rounds and saturates the sum to signed Q3.30.
// ----------------------------------------------------------------------------
module dm_mac (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dm_pkg::dm_mac_ctl_t            ctl,
  input  logic [dm_pkg::VAL_W-1:0]       occ_q,
  input  logic [dm_pkg::VAL_W-1:0]       a_q,
  input  logic [dm_pkg::VAL_W-1:0]       b_q,
  output logic                           busy,
  output logic signed [dm_pkg::OUT_W-1:0] dens
);
  import dm_pkg::*;

  localparam int SHR   = 3 * FRAC_BITS - OUT_FRAC;
  localparam int SHL   = OUT_FRAC - 3 * FRAC_BITS;
  localparam int RES_W = ACC_W + 2 + ((SHL > 0) ? SHL : 0);

  logic                      s0_v_r, s1_v_r, s2_v_r;
  logic signed [2*VAL_W-1:0] p1_r;
  logic signed [VAL_W-1:0]   bd_r;
  logic signed [3*VAL_W-1:0] p2_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   acc_nxt;
  logic signed [RES_W-1:0]   ext;
  logic signed [RES_W-1:0]   scaled;

  localparam logic signed [RES_W-1:0] OMAX = (RES_W'(1) <<< (OUT_W - 1)) - RES_W'(1);
  localparam logic signed [RES_W-1:0] OMIN = -(RES_W'(1) <<< (OUT_W - 1));

  // memory read data lands in the cycle after issue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s0_v_r <= ctl.issue;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_r  <= $signed(occ_q) * $signed(a_q);
    bd_r  <= $signed(b_q);
    p2_r  <= p1_r * bd_r;
    acc_r <= acc_nxt;
  end

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clr) begin
      acc_nxt = '0;
    end else if (s2_v_r) begin
      acc_nxt = acc_r + (ACC_W'(p2_r) <<< 1);
    end
  end

  assign busy = s0_v_r | s1_v_r | s2_v_r;
  assign ext  = RES_W'(acc_r);

  generate
    if (SHR > 0) begin : g_round
      localparam logic signed [RES_W-1:0] HALF = RES_W'(1) <<< (SHR - 1);
      // round half up: add half an output lsb, then floor
      assign scaled = (ext + HALF) >>> SHR;
    end else begin : g_scale
      assign scaled = ext <<< SHL;
    end
  endgenerate

  always_comb begin
    if (scaled > OMAX) begin
      dens = OMAX[OUT_W-1:0];
    end else if (scaled < OMIN) begin
      dens = OMIN[OUT_W-1:0];
    end else begin
      dens = scaled[OUT_W-1:0];
    end
  end

endmodule

// ----- rtl/core/block_density_matrix.sv -----
// ----------------------------------------------------------------------------
// block_density_matrix
// Density matrix element of one basis block from stored occupations and
// eigenvectors, with global and packed lower-triangle addresses.
// ----------------------------------------------------------------------------
// Loads are taken one per cycle while idle. A compute item issues one MAC
// term per cycle (n = effective block size terms) to the shared three-stage
// multiply-accumulate, lets it drain, then loads the result register; the
// next item is taken after that. An index error goes straight to the finish
// step; a result not yet taken holds that step. Reset (rst_n, sync, active low)
// clears control only; block_size = 32, block_offset = 0; stores undefined.
// ----------------------------------------------------------------------------
module block_density_matrix (
  input  logic        clk,
  input  logic        rst_n,
  dm_in_if.sink       in_chan,
  dm_out_if.source    out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [SIZE_W-1:0]  block_size_r;
  logic [GIDX_W-1:0]  block_offset_r;
  logic [CNT_W-1:0]   t_r, t_nxt;
  logic [CNT_W-1:0]   n_r;
  logic [IDX_W-1:0]   i_r, j_r;
  logic [GIDX_W-1:0]  row_r, col_r;
  logic               err_r;

  logic               out_valid_r;
  logic [GIDX_W-1:0]  out_row_r, out_col_r;
  logic [PIDX_W-1:0]  out_pidx_r;
  logic [OUT_W-1:0]   out_dens_r;
  logic               out_status_r;

  logic               accept, start, cmp_err, out_load;
  logic [CMP_W-1:0]   n_eff;
  logic [GIDX_W:0]    row_sum, col_sum;
  logic [2*GIDX_W:0]  tri_prod;
  logic [PIDX_W-1:0]  pidx;
  logic               cfg_wr;

  dm_wr_t             wr;
  dm_rd_t             rd;
  dm_mac_ctl_t        mac_ctl;
  logic [VAL_W-1:0]   occ_q, a_q, b_q;
  logic               mac_busy;
  logic signed [OUT_W-1:0] mac_dens;

  // ---- configuration port ----
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r   <= BLOCK_SIZE_RST;
      block_offset_r <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_BLOCK_SIZE:   block_size_r   <= pwdata[SIZE_W-1:0];
        REG_BLOCK_OFFSET: block_offset_r <= pwdata[GIDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BLOCK_SIZE:   prdata = 32'(block_size_r);
      REG_BLOCK_OFFSET: prdata = 32'(block_offset_r);
      default:          prdata = '0;
    endcase
  end

  // ---- request decode ----
  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept = in_chan.valid & in_chan.ready;

  assign n_eff = (CMP_W'(block_size_r) < CMP_W'(MAX_N)) ? CMP_W'(block_size_r)
                                                         : CMP_W'(MAX_N);
  assign row_sum = (GIDX_W+1)'(block_offset_r) + (GIDX_W+1)'(in_chan.index_i);
  assign col_sum = (GIDX_W+1)'(block_offset_r) + (GIDX_W+1)'(in_chan.index_k);
  assign cmp_err = (CMP_W'(in_chan.index_i) >= n_eff) ||
                   (CMP_W'(in_chan.index_k) >= n_eff) ||
                   (in_chan.index_k > in_chan.index_i) ||
                   row_sum[GIDX_W];
  assign start = accept && (in_chan.op == OP_COMPUTE);

  always_comb begin
    wr.occ_we   = accept && (in_chan.op == OP_LOAD_OCC) &&
                  (CMP_W'(in_chan.index_k) < CMP_W'(MAX_N));
    wr.eig_we   = accept && (in_chan.op == OP_LOAD_VEC) &&
                  (CMP_W'(in_chan.index_k) < CMP_W'(MAX_N)) &&
                  (CMP_W'(in_chan.index_i) < CMP_W'(MAX_N));
    wr.occ_addr = MA_W'(in_chan.index_k);
    wr.eig_addr = EA_W'(in_chan.index_k) * EA_W'(MAX_N) + EA_W'(in_chan.index_i);
    wr.data     = in_chan.value;
  end

  always_comb begin
    rd.occ_addr = t_r[MA_W-1:0];
    rd.a_addr   = EA_W'(t_r) * EA_W'(MAX_N) + EA_W'(i_r);
    rd.b_addr   = EA_W'(t_r) * EA_W'(MAX_N) + EA_W'(j_r);
  end

  assign mac_ctl.clr   = start;
  assign mac_ctl.issue = (state_r == ST_RUN);

  // ---- sequencer ----
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt = state_r;
    t_nxt     = t_r;
    case (state_r)
      ST_IDLE: begin
        t_nxt = '0;
        if (start) begin
          state_nxt = cmp_err ? ST_OUT : ST_RUN;
        end
      end
      ST_RUN: begin
        t_nxt = t_r + CNT_W'(1);
        if (t_r == n_r - CNT_W'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      t_r     <= '0;
    end else begin
      state_r <= state_nxt;
      t_r     <= t_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= CNT_W'(n_eff);
      i_r   <= in_chan.index_i;
      j_r   <= in_chan.index_k;
      row_r <= row_sum[GIDX_W-1:0];
      col_r <= col_sum[GIDX_W-1:0];
      err_r <= cmp_err;
    end
  end

  // packed lower-triangle address row*(row+1)/2 + col
  assign tri_prod = (2*GIDX_W+1)'(row_r) * (2*GIDX_W+1)'({1'b0, row_r} + (GIDX_W+1)'(1));
  assign pidx     = PIDX_W'((tri_prod >> 1) + (2*GIDX_W+1)'(col_r));

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row_r    <= err_r ? '0 : row_r;
      out_col_r    <= err_r ? '0 : col_r;
      out_pidx_r   <= err_r ? '0 : pidx;
      out_dens_r   <= err_r ? '0 : mac_dens;
      out_status_r <= err_r;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.row_global    = out_row_r;
  assign out_chan.col_global    = out_col_r;
  assign out_chan.packed_index  = out_pidx_r;
  assign out_chan.density_value = out_dens_r;
  assign out_chan.status        = out_status_r;

  // ---- datapath ----
  dm_store u_store (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .occ_q (occ_q),
    .a_q   (a_q),
    .b_q   (b_q)
  );

  dm_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .occ_q (occ_q),
    .a_q   (a_q),
    .b_q   (b_q),
    .busy  (mac_busy),
    .dens  (mac_dens)
  );

  // ---- checks ----
  a_idle_mac_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mac_busy)
    else $error("MAC pipeline active while idle");

  a_run_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (t_r < n_r))
    else $error("term counter beyond block size");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.status) |->
      (out_chan.density_value == '0 && out_chan.packed_index == '0))
    else $error("error item carries nonzero payload");

endmodule

// ----- dv/tb_block_density_matrix.sv -----
// ----------------------------------------------------------------------------
// tb_block_density_matrix
// Self-checking bench for the block density matrix unit. A short scripted
// sequence covers saturation, index errors, block offset at the top of the
// global range and the ignored op code. Random phases follow: each phase sets
// block size and offset, loads the occupations and the eigenvector columns it
// needs, then issues compute items. Every result is checked field by field
// against a scripted value or the in-bench accumulate/round/saturate model.
// ----------------------------------------------------------------------------
module tb_block_density_matrix;
  timeunit 1ns;
  timeprecision 1ps;

  import dm_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int     ITEM_TARGET  = 1030;
  localparam int     DRAIN_CYCLES = MAX_N + 16;
  localparam int     RND_SH       = 3 * FRAC_BITS - OUT_FRAC;
  localparam int     GIDX_MAX     = (1 << GIDX_W) - 1;
  localparam longint DENS_HI      = (longint'(1) <<< (OUT_W - 1)) - 1;
  localparam longint DENS_LO      = -(longint'(1) <<< (OUT_W - 1));

  typedef struct packed {
    logic [GIDX_W-1:0] row_g;
    logic [GIDX_W-1:0] col_g;
    logic [PIDX_W-1:0] pk_idx;
    logic [OUT_W-1:0]  dens;
    logic              status;
  } dm_result_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_SET_SIZE, ROW_SET_OFFSET} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  k;
    logic [IDX_W-1:0]  i;
    logic [VAL_W-1:0]  value;
    bit                fixed_exp;
    dm_result_t        res;
  } script_row_t;

  localparam dm_result_t RES_NONE   = '0;
  localparam dm_result_t RES_ERROR  = '{row_g: '0, col_g: '0, pk_idx: '0, dens: '0,
                                        status: 1'b1};
  localparam dm_result_t RES_SAT_LO = '{row_g: '0, col_g: '0, pk_idx: '0,
                                        dens: OUT_W'(DENS_LO), status: 1'b0};
  localparam dm_result_t RES_SAT_HI = '{row_g: '0, col_g: '0, pk_idx: '0,
                                        dens: OUT_W'(DENS_HI), status: 1'b0};
  // 2.0 at the last global row and column
  localparam dm_result_t RES_TOP    = '{row_g: 12'd4095, col_g: 12'd4095,
                                        pk_idx: 24'd8390655, dens: 34'd2147483648,
                                        status: 1'b0};

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  dm_in_if  in_if ();
  dm_out_if out_if ();

  block_density_matrix dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // model state
  logic signed [VAL_W-1:0] occ_mem [MAX_N];
  logic signed [VAL_W-1:0] vec_mem [MAX_N*MAX_N];
  bit                      occ_loaded [MAX_N];
  bit                      vec_loaded [MAX_N*MAX_N];
  logic [SIZE_W-1:0]       size_reg   = BLOCK_SIZE_RST;
  logic [GIDX_W-1:0]       offset_reg = '0;

  dm_result_t pending_elements [$];
  int         mismatch_count = 0;
  int         items_done = 0;
  bit         src_quiet = 1'b0;
  bit         snk_quiet = 1'b0;

  script_row_t script [0:27] = '{
    '{ROW_ITEM,       OP_COMPUTE,  5'd1,  5'd0,  16'h0000, 1'b1, RES_ERROR},
    '{ROW_ITEM,       OP_COMPUTE,  5'd31, 5'd30, 16'h0000, 1'b1, RES_ERROR},
    '{ROW_ITEM,       OP_UNUSED,   5'd31, 5'd31, 16'hFFFF, 1'b0, RES_NONE},
    '{ROW_SET_SIZE,   OP_LOAD_OCC, 5'd0,  5'd0,  16'd1,    1'b0, RES_NONE},
    '{ROW_ITEM,       OP_LOAD_OCC, 5'd0,  5'd0,  16'h8000, 1'b0, RES_NONE},
    '{ROW_ITEM,       OP_LOAD_VEC, 5'd0,  5'd0,  16'h8000, 1'b0, RES_NONE},
    '{ROW_ITEM,       OP_COMPUTE,  5'd0,  5'd0,  16'h0000, 1'b1, RES_SAT_LO},
    '{ROW_ITEM,       OP_LOAD_OCC, 5'd0,  5'd0,  16'h7FFF, 1'b0, RES_NONE},
    '{ROW_ITEM,       OP_COMPUTE,  5'd0,  5'd0,  16'h0000, 1'b1, RES_SAT_HI},
    '{ROW_ITEM,       OP_COMPUTE,  5'd1,  5'd1,  16'h0000, 1'b1, RES_ERROR},
    '{ROW_ITEM,       OP_LOAD_OCC, 5'd0,  5'd0,  16'h4000, 1'b0, RES_NONE},
    '{ROW_ITEM,       OP_LOAD_VEC, 5'd0,  5'd0,  16'h4000, 1'b0, RES_NONE},
    '{ROW_SET_OFFSET, OP_LOAD_OCC, 5'd0,  5'd0,  16'd4095, 1'b0, RES_NONE},
    '{ROW_ITEM,       OP_COMPUTE,  5'd0,  5'd0,  16'h0000, 1'b1, RES_TOP},
    '{ROW_SET_SIZE,   OP_LOAD_OCC, 5'd0,  5'd0,  16'd2,    1'b0, RES_NONE},
    // global row runs past the top
    '{ROW_ITEM,       OP_COMPUTE,  5'd0,  5'd1,  16'h0000, 1'b1, RES_ERROR},
    '{ROW_SET_OFFSET, OP_LOAD_OCC, 5'd0,  5'd0,  16'd0,    1'b0, RES_NONE},
    '{ROW_ITEM,       OP_LOAD_OCC, 5'd1,  5'd31, 16'hFFFF, 1'b0, RES_NONE},
    '{ROW_ITEM,       OP_LOAD_VEC, 5'd0,  5'd1,  16'h7FFF, 1'b0, RES_NONE},
    '{ROW_ITEM,       OP_LOAD_VEC, 5'd1,  5'd0,  16'h8001, 1'b0, RES_NONE},
    '{ROW_ITEM,       OP_LOAD_VEC, 5'd1,  5'd1,  16'h1234, 1'b0, RES_NONE},
    '{ROW_ITEM,       OP_COMPUTE,  5'd0,  5'd1,  16'h0000, 1'b0, RES_NONE},
    '{ROW_ITEM,       OP_COMPUTE,  5'd1,  5'd1,  16'h0000, 1'b0, RES_NONE},
    '{ROW_SET_SIZE,   OP_LOAD_OCC, 5'd0,  5'd0,  16'd0,    1'b0, RES_NONE},
    '{ROW_ITEM,       OP_COMPUTE,  5'd0,  5'd0,  16'h0000, 1'b1, RES_ERROR},
    // oversize block clamps to MAX_N
    '{ROW_SET_SIZE,   OP_LOAD_OCC, 5'd0,  5'd0,  16'd63,   1'b0, RES_NONE},
    '{ROW_SET_OFFSET, OP_LOAD_OCC, 5'd0,  5'd0,  16'd4064, 1'b0, RES_NONE},
    '{ROW_ITEM,       OP_COMPUTE,  5'd5,  5'd2,  16'h0000, 1'b1, RES_ERROR}
  };

  function automatic int eff_size();
    return (size_reg < MAX_N) ? int'(size_reg) : MAX_N;
  endfunction

  function automatic bit is_error(logic [IDX_W-1:0] col_j, logic [IDX_W-1:0] row_i);
    return (int'(row_i) >= eff_size()) || (int'(col_j) >= eff_size()) || (col_j > row_i) ||
           (int'(offset_reg) + int'(row_i) > GIDX_MAX);
  endfunction

  function automatic dm_result_t density_element(logic [IDX_W-1:0] col_j,
                                                 logic [IDX_W-1:0] row_i);
    dm_result_t res;
    int         t;
    longint     row_gl;
    longint     col_gl;
    longint     acc;
    longint     scaled;
    res = '0;
    if (is_error(col_j, row_i)) begin
      res.status = 1'b1;
      return res;
    end
    row_gl = longint'(offset_reg) + longint'(row_i);
    col_gl = longint'(offset_reg) + longint'(col_j);
    acc = 0;
    for (t = 0; t < eff_size(); t++) begin
      acc += 2 * longint'(occ_mem[t]) * longint'(vec_mem[t*MAX_N + int'(row_i)]) *
             longint'(vec_mem[t*MAX_N + int'(col_j)]);
    end
    // round half up into Q3.30, then clamp
    scaled = (acc + (longint'(1) <<< (RND_SH - 1))) >>> RND_SH;
    if (scaled > DENS_HI) scaled = DENS_HI;
    else if (scaled < DENS_LO) scaled = DENS_LO;
    res.row_g  = GIDX_W'(row_gl);
    res.col_g  = GIDX_W'(col_gl);
    res.pk_idx = PIDX_W'(row_gl * (row_gl + 1) / 2 + col_gl);
    res.dens   = OUT_W'(scaled);
    return res;
  endfunction

  // true when the element can be requested without touching unloaded entries
  function automatic bit reads_loaded(logic [IDX_W-1:0] col_j, logic [IDX_W-1:0] row_i);
    int t;
    if (is_error(col_j, row_i)) return 1'b1;
    for (t = 0; t < eff_size(); t++) begin
      if (!occ_loaded[t] || !vec_loaded[t*MAX_N + int'(row_i)] ||
          !vec_loaded[t*MAX_N + int'(col_j)]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void accept_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] k,
                                      logic [IDX_W-1:0] i, logic [VAL_W-1:0] value,
                                      bit fixed_exp, dm_result_t fixed_res);
    case (op)
      OP_LOAD_OCC: begin
        occ_mem[k]    = value;
        occ_loaded[k] = 1'b1;
      end
      OP_LOAD_VEC: begin
        vec_mem[int'(k)*MAX_N + int'(i)]    = value;
        vec_loaded[int'(k)*MAX_N + int'(i)] = 1'b1;
      end
      OP_COMPUTE: begin
        pending_elements.push_back(fixed_exp ? fixed_res : density_element(k, i));
      end
      default: ;
    endcase
    if (op != OP_UNUSED) items_done++;
  endfunction

  function automatic int draw_gap(inout bit quiet);
    if ($urandom_range(0, 39) == 0) quiet = !quiet;
    return quiet ? 0 : int'($urandom_range(0, 9));
  endfunction

  function automatic logic [IDX_W-1:0] rand_idx();
    return IDX_W'($urandom_range(0, MAX_N - 1));
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    if ($urandom_range(0, 7) != 0) return VAL_W'($urandom);
    case ($urandom_range(0, 5))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4:       return 16'h4000;
      default: return 16'hC000;
    endcase
  endfunction

  function automatic int unsigned pick_size();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return 0;
    if (roll < 70) return $urandom_range(1, 6);
    if (roll < 85) return $urandom_range(7, 16);
    if (roll < 95) return $urandom_range(17, 32);
    return $urandom_range(33, 63);
  endfunction

  function automatic int unsigned pick_offset();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return 0;
    if (roll < 40) return GIDX_MAX - $urandom_range(0, 40);
    return $urandom_range(0, GIDX_MAX);
  endfunction

  function automatic void flag_mismatch(string field, logic [63:0] want, logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s differs: expected %0h, got %0h", $realtime, field, want, got);
  endfunction

  // entered and left at a falling edge
  task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] k,
                           input logic [IDX_W-1:0] i, input logic [VAL_W-1:0] value,
                           input bit fixed_exp, input dm_result_t fixed_res);
    int gap;
    gap = draw_gap(src_quiet);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.op      <= op;
    in_if.index_k <= k;
    in_if.index_i <= i;
    in_if.value   <= value;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    accept_item(op, k, i, value, fixed_exp, fixed_res);
    @(negedge clk);
  endtask

  task automatic maybe_noise();
    if ($urandom_range(0, 15) == 0) begin
      case ($urandom_range(0, 2))
        0:       send_item(OP_UNUSED, rand_idx(), rand_idx(), rand_value(), 1'b0, RES_NONE);
        1:       send_item(OP_LOAD_OCC, rand_idx(), rand_idx(), rand_value(), 1'b0, RES_NONE);
        default: send_item(OP_LOAD_VEC, rand_idx(), rand_idx(), rand_value(), 1'b0, RES_NONE);
      endcase
    end
  endtask

  // wait for every result, then for a possible trailing compute to finish
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_elements.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic reg_sel, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (reg_sel == REG_BLOCK_SIZE) size_reg = data[SIZE_W-1:0];
    else offset_reg = data[GIDX_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : result_sink
    int gap;
    out_if.ready = 1'b0;
    forever begin
      gap = draw_gap(snk_quiet);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!(out_if.valid && out_if.ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    dm_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_elements.size() == 0) begin
        flag_mismatch("unrequested item, row_global", 64'd0, 64'(out_if.row_global));
      end else begin
        want = pending_elements.pop_front();
        if (out_if.row_global !== want.row_g)
          flag_mismatch("row_global", 64'(want.row_g), 64'(out_if.row_global));
        if (out_if.col_global !== want.col_g)
          flag_mismatch("col_global", 64'(want.col_g), 64'(out_if.col_global));
        if (out_if.packed_index !== want.pk_idx)
          flag_mismatch("packed_index", 64'(want.pk_idx), 64'(out_if.packed_index));
        if (out_if.density_value !== want.dens)
          flag_mismatch("density_value", 64'(want.dens), 64'(out_if.density_value));
        if (out_if.status !== want.status)
          flag_mismatch("status", 64'(want.status), 64'(out_if.status));
      end
    end
  end

  initial begin : stimulus
    int                t;
    int                s;
    int                eff_n;
    int                n_act;
    int                cand;
    int                a;
    int                b;
    int                act_list [$];
    bit                act_mark [MAX_N];
    logic [IDX_W-1:0]  ck;
    logic [IDX_W-1:0]  ci;
    int unsigned       size_val;
    int unsigned       offset_val;

    in_if.valid   = 1'b0;
    in_if.op      = OP_LOAD_OCC;
    in_if.index_k = '0;
    in_if.index_i = '0;
    in_if.value   = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    rst_n   = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (script[r]) begin
      case (script[r].kind)
        ROW_SET_SIZE: begin
          settle();
          write_reg(REG_BLOCK_SIZE, {16'd0, script[r].value});
        end
        ROW_SET_OFFSET: begin
          settle();
          write_reg(REG_BLOCK_OFFSET, {16'd0, script[r].value});
        end
        default: begin
          send_item(script[r].op, script[r].k, script[r].i, script[r].value,
                    script[r].fixed_exp, script[r].res);
        end
      endcase
    end

    // random phases: configure, load what the chosen columns need, compute
    while (items_done < ITEM_TARGET) begin
      settle();
      size_val   = pick_size();
      offset_val = pick_offset();
      write_reg(REG_BLOCK_SIZE, size_val);
      write_reg(REG_BLOCK_OFFSET, offset_val);
      eff_n = eff_size();
      n_act = (eff_n == 0) ? 0 : int'($urandom_range(1, (eff_n < 4) ? eff_n : 4));
      act_list.delete();
      foreach (act_mark[s]) act_mark[s] = 1'b0;
      while (act_list.size() < n_act) begin
        cand = $urandom_range(0, eff_n - 1);
        if (!act_mark[cand]) begin
          act_mark[cand] = 1'b1;
          act_list.push_back(cand);
        end
      end

      for (t = 0; t < eff_n; t++) begin
        maybe_noise();
        if (!occ_loaded[t] || $urandom_range(0, 1) == 0)
          send_item(OP_LOAD_OCC, IDX_W'(t), rand_idx(), rand_value(), 1'b0, RES_NONE);
        for (s = 0; s < eff_n; s++) begin
          if (act_mark[s] && (!vec_loaded[t*MAX_N + s] || $urandom_range(0, 3) == 0))
            send_item(OP_LOAD_VEC, IDX_W'(t), IDX_W'(s), rand_value(), 1'b0, RES_NONE);
        end
      end

      repeat ($urandom_range(2, 10)) begin
        maybe_noise();
        if (n_act > 0 && $urandom_range(0, 7) != 0) begin
          a = act_list[$urandom_range(0, n_act - 1)];
          b = act_list[$urandom_range(0, n_act - 1)];
          ck = IDX_W'((a < b) ? a : b);
          ci = IDX_W'((a < b) ? b : a);
        end else begin
          do begin
            ck = rand_idx();
            ci = rand_idx();
          end while (!reads_loaded(ck, ci));
        end
        send_item(OP_COMPUTE, ck, ci, rand_value(), 1'b0, RES_NONE);
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/dm_pkg.sv
rtl/core/dm_in_if.sv
rtl/core/dm_out_if.sv
rtl/core/dm_store.sv
rtl/core/dm_mac.sv
rtl/core/block_density_matrix.sv
dv/tb_block_density_matrix.sv
